FILE: rtl/double_hash_open_address_table_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the double hash open address table
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_HASH_OPEN_ADDRESS_TABLE_ASSERT_SVH
`define DOUBLE_HASH_OPEN_ADDRESS_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
`define DHOT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("dhot assertion failed");
`define DHOT_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("dhot forbidden condition seen");
`else
`define DHOT_ASSERT(lbl, prop)
`define DHOT_ASSERT_NEVER(lbl, cond)
`endif

`endif

FILE: rtl/dhot_pkg.sv
// ---------------------------------------------------------------------------
// dhot_pkg
// Sizes, word types and derived constants of the double hash table.
// ---------------------------------------------------------------------------
package dhot_pkg;

  // table size is a power of two: a slot index is the low SLOT_W bits
  localparam int unsigned TABLE_SLOTS = 1024;
  localparam int unsigned KEY_W       = 31;
  localparam int unsigned PAYLOAD_W   = 64;
  localparam int unsigned FOLD_SHIFT  = 10;

  localparam int unsigned SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int unsigned COUNT_W = $clog2(TABLE_SLOTS + 1);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [KEY_W-1:0]     HOME_MASK  = KEY_W'(TABLE_SLOTS - 1);
  localparam logic [KEY_W-1:0]     STEP_MASK  = KEY_W'(TABLE_SLOTS - 2);
  localparam logic [SLOT_W:0]      SLOTS_X    = (SLOT_W + 1)'(TABLE_SLOTS);
  localparam logic [SLOT_W-1:0]    LAST_SLOT  = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [COUNT_W-1:0]   FULL_COUNT = COUNT_W'(TABLE_SLOTS);

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_LOOKUP = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e                mode;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload_in;
  } in_item_t;

  typedef struct packed {
    logic                 success;
    logic [PAYLOAD_W-1:0] payload_out;
  } out_item_t;

  // classified operation handed from the front to the back
  typedef struct packed {
    mode_e                mode;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
    logic [SLOT_W-1:0]    home;
    logic [SLOT_W-1:0]    step;
  } op_item_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

FILE: rtl/double_hash_open_address_table.sv
// ---------------------------------------------------------------------------
// double_hash_open_address_table
// Open-addressed key/payload table with double hashing; insert and lookup.
// ---------------------------------------------------------------------------
// Path: the front registers the word, the queue holds it, and the back pops
//   it, probes through the registered slot read and registers the result.
// The back takes one word at a time, popping the next only once the last
//   result is registered; its one slot read port sets one probe a cycle.
// Reset: rst_ni clears control state, then a pass over all TABLE_SLOTS (1024)
//   slots marks every slot empty; in_ready_o stays low during that pass.
module double_hash_open_address_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dhot_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dhot_pkg::out_item_t out_data_o
);

  dhot_pkg::back_status_t back_status;
  logic                   fq_valid, fq_ready;
  dhot_pkg::op_item_t     fq_data;
  logic                   qb_valid, qb_ready;
  dhot_pkg::op_item_t     qb_data;

  dhot_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .status_i   (back_status),
    .q_valid_o  (fq_valid),
    .q_ready_i  (fq_ready),
    .q_data_o   (fq_data)
  );

  dhot_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_data),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_data)
  );

  dhot_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (qb_valid),
    .q_ready_o   (qb_ready),
    .q_data_i    (qb_data),
    .status_o    (back_status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/dhot_fifo.sv
// ---------------------------------------------------------------------------
// dhot_fifo
// Short queue of classified operations between the front and the back.
// ---------------------------------------------------------------------------
module dhot_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  dhot_pkg::op_item_t  push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output dhot_pkg::op_item_t  pop_data_o
);

  dhot_pkg::op_item_t               entries [dhot_pkg::QUEUE_DEPTH];
  logic [dhot_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [dhot_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [dhot_pkg::QCNT_W-1:0]      count_q, count_d;
  logic                             push, pop;

  assign push_ready_o = (count_q != dhot_pkg::QCNT_W'(dhot_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entries[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == dhot_pkg::QPTR_W'(dhot_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + dhot_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == dhot_pkg::QPTR_W'(dhot_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + dhot_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + dhot_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - dhot_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/dhot_front.sv
// ---------------------------------------------------------------------------
// dhot_front
// Accepts words, folds the key into home slot and probe step within the
// table, and hands the classified operation to the queue.
// ---------------------------------------------------------------------------
module dhot_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  dhot_pkg::in_item_t     in_data_i,
  input  dhot_pkg::back_status_t status_i,
  output logic                   q_valid_o,
  input  logic                   q_ready_i,
  output dhot_pkg::op_item_t     q_data_o
);

  typedef enum logic {
    FR_IDLE,
    FR_PUSH
  } front_state_e;

  front_state_e                     state_q, state_d;
  dhot_pkg::in_item_t               item_q, item_d;
  logic                             accept;

  // fold hash reduced to a slot index; the modulo keeps the low slot bits
  function automatic logic [dhot_pkg::SLOT_W-1:0] fold_hash(
    input logic [dhot_pkg::KEY_W-1:0] key,
    input logic [dhot_pkg::KEY_W-1:0] mask
  );
    return dhot_pkg::SLOT_W'(key >> dhot_pkg::FOLD_SHIFT) ^
           dhot_pkg::SLOT_W'(key & mask);
  endfunction

  assign in_ready_o = !status_i.clearing &&
                      ((state_q == FR_IDLE) || ((state_q == FR_PUSH) && q_ready_i));
  assign accept     = in_valid_i && in_ready_o;
  assign q_valid_o  = (state_q == FR_PUSH);

  always_comb begin
    q_data_o.mode    = item_q.mode;
    q_data_o.key     = item_q.key;
    q_data_o.payload = item_q.payload_in;
    q_data_o.home    = fold_hash(item_q.key, dhot_pkg::HOME_MASK);
    // step is fold + 1, wrapped within the slot bits
    q_data_o.step    = fold_hash(item_q.key, dhot_pkg::STEP_MASK) +
                       dhot_pkg::SLOT_W'(1);
  end

  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    unique case (state_q)
      FR_IDLE: ;
      FR_PUSH: begin
        if (q_ready_i) begin
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
    if (accept) begin
      item_d  = in_data_i;
      state_d = FR_PUSH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      item_q  <= '0;
    end else begin
      state_q <= state_d;
      item_q  <= item_d;
    end
  end

endmodule

FILE: rtl/dhot_back.sv
// ---------------------------------------------------------------------------
// dhot_back
// Slot memory and probe engine: clears the table after reset, then runs
// each queued insert or lookup one probe per cycle and registers the result.
// ---------------------------------------------------------------------------
`include "double_hash_open_address_table_assert.svh"

module dhot_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  output logic                   q_ready_o,
  input  dhot_pkg::op_item_t     q_data_i,
  output dhot_pkg::back_status_t status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output dhot_pkg::out_item_t    out_data_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } back_state_e;

  typedef struct packed {
    logic                           used;
    logic [dhot_pkg::KEY_W-1:0]     key;
    logic [dhot_pkg::PAYLOAD_W-1:0] payload;
  } rec_t;

  back_state_e                   state_q, state_d;
  logic [dhot_pkg::SLOT_W-1:0]   clr_cnt_q, clr_cnt_d;
  logic [dhot_pkg::SLOT_W-1:0]   cur_slot_q, cur_slot_d;
  logic [dhot_pkg::SLOT_W-1:0]   probe_cnt_q, probe_cnt_d;
  dhot_pkg::op_item_t            op_q, op_d;
  logic [dhot_pkg::COUNT_W-1:0]  count_q, count_d;
  logic                          out_valid_q, out_valid_d;
  dhot_pkg::out_item_t           out_q, out_d;

  rec_t                          slot_mem [dhot_pkg::TABLE_SLOTS];
  rec_t                          rd_data_q;
  logic                          wr_en;
  logic [dhot_pkg::SLOT_W-1:0]   wr_addr;
  rec_t                          wr_data;
  logic [dhot_pkg::SLOT_W-1:0]   rd_addr;

  logic                          out_free;
  logic                          pop;
  logic                          done;
  dhot_pkg::out_item_t           result;
  logic [dhot_pkg::SLOT_W:0]     slot_sum;
  logic [dhot_pkg::SLOT_W-1:0]   next_slot;

  assign out_free    = !out_valid_q || out_ready_i;
  assign q_ready_o   = pop;
  assign status_o.clearing = (state_q == ST_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // next probe slot, both terms already below the table size
  assign slot_sum  = {1'b0, cur_slot_q} + {1'b0, op_q.step};
  assign next_slot = (slot_sum >= dhot_pkg::SLOTS_X) ?
                     dhot_pkg::SLOT_W'(slot_sum - dhot_pkg::SLOTS_X) :
                     slot_sum[dhot_pkg::SLOT_W-1:0];

  // outcome of the slot read last cycle
  always_comb begin
    done   = 1'b0;
    result = '0;
    if (!rd_data_q.used) begin
      done           = 1'b1;
      result.success = (op_q.mode == dhot_pkg::MODE_INSERT);
    end else if ((op_q.mode == dhot_pkg::MODE_LOOKUP) && (rd_data_q.key == op_q.key)) begin
      done               = 1'b1;
      result.success     = 1'b1;
      result.payload_out = rd_data_q.payload;
    end else if (probe_cnt_q == dhot_pkg::LAST_SLOT) begin
      done = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    cur_slot_d  = cur_slot_q;
    probe_cnt_d = probe_cnt_q;
    op_d        = op_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    pop         = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = cur_slot_q;
    wr_data     = '0;
    rd_addr     = cur_slot_q;
    unique case (state_q)
      ST_CLEAR: begin
        wr_en     = 1'b1;
        wr_addr   = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + dhot_pkg::SLOT_W'(1);
        if (clr_cnt_q == dhot_pkg::LAST_SLOT) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          if ((q_data_i.mode == dhot_pkg::MODE_INSERT) &&
              (count_q == dhot_pkg::FULL_COUNT)) begin
            // table full: answer without probing
            if (out_free) begin
              pop         = 1'b1;
              out_valid_d = 1'b1;
              out_d       = '0;
            end
          end else begin
            pop         = 1'b1;
            op_d        = q_data_i;
            cur_slot_d  = q_data_i.home;
            rd_addr     = q_data_i.home;
            probe_cnt_d = '0;
            state_d     = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        if (!done) begin
          cur_slot_d  = next_slot;
          rd_addr     = next_slot;
          probe_cnt_d = probe_cnt_q + dhot_pkg::SLOT_W'(1);
        end else if (out_free) begin
          if (!rd_data_q.used && (op_q.mode == dhot_pkg::MODE_INSERT)) begin
            wr_en           = 1'b1;
            wr_data.used    = 1'b1;
            wr_data.key     = op_q.key;
            wr_data.payload = op_q.payload;
            count_d         = count_q + dhot_pkg::COUNT_W'(1);
          end
          out_valid_d = 1'b1;
          out_d       = result;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      cur_slot_q  <= '0;
      probe_cnt_q <= '0;
      op_q        <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      cur_slot_q  <= cur_slot_d;
      probe_cnt_q <= probe_cnt_d;
      op_q        <= op_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= slot_mem[rd_addr];
  end

  `DHOT_ASSERT_NEVER(a_count_bound, count_q > dhot_pkg::FULL_COUNT)
  `DHOT_ASSERT_NEVER(a_no_pop_clear, (state_q == ST_CLEAR) && q_ready_o)
  `DHOT_ASSERT_NEVER(a_lookup_no_write, (state_q == ST_LOOK) && wr_en && (op_q.mode == dhot_pkg::MODE_LOOKUP))
  `DHOT_ASSERT(a_count_step, (count_q != $past(count_q)) |-> (count_q == $past(count_q) + dhot_pkg::COUNT_W'(1)))
  `DHOT_ASSERT(a_done_emits, ((state_q == ST_LOOK) && done && out_free) |=> (out_valid_q && (state_q == ST_IDLE)))

endmodule

FILE: dv/double_hash_open_address_table_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// double_hash_open_address_table_test
// Self-checking bench for the double hash table. Directed inserts and
// lookups come first. A random mix of inserts and lookups follows, then the
// table is filled and exercised while full. A scoreboard keeps its own copy
// of the slot table and checks every result word in order.
// ---------------------------------------------------------------------------
module double_hash_open_address_table_test;

  class slot_table_scoreboard;
    bit                           slot_used    [dhot_pkg::TABLE_SLOTS];
    bit [dhot_pkg::KEY_W-1:0]     slot_key     [dhot_pkg::TABLE_SLOTS];
    bit [dhot_pkg::PAYLOAD_W-1:0] slot_payload [dhot_pkg::TABLE_SLOTS];
    int unsigned                  entries;
    dhot_pkg::out_item_t          due_results [$];
    int                           fail_count;

    function new();
      entries    = 0;
      fail_count = 0;
      foreach (slot_used[s]) slot_used[s] = 1'b0;
    endfunction

    // walk the probe path of one operation and update the table copy
    function dhot_pkg::out_item_t run_op(dhot_pkg::in_item_t w);
      dhot_pkg::out_item_t      r;
      bit [dhot_pkg::KEY_W-1:0] k;
      longint unsigned          hi, home, stride;
      int unsigned              s;
      r      = '0;
      k      = w.key;
      hi     = k >> dhot_pkg::FOLD_SHIFT;
      home   = hi ^ (k & (dhot_pkg::TABLE_SLOTS - 1));
      stride = (hi ^ (k & (dhot_pkg::TABLE_SLOTS - 2))) + 1;
      if (w.mode == dhot_pkg::MODE_INSERT) begin
        if (entries >= dhot_pkg::TABLE_SLOTS) return r;
        for (longint unsigned i = 0; i < dhot_pkg::TABLE_SLOTS; i++) begin
          s = int'((home + i * stride) % dhot_pkg::TABLE_SLOTS);
          if (!slot_used[s]) begin
            slot_used[s]    = 1'b1;
            slot_key[s]     = k;
            slot_payload[s] = w.payload_in;
            entries++;
            r.success = 1'b1;
            return r;
          end
        end
        return r;
      end
      for (longint unsigned i = 0; i < dhot_pkg::TABLE_SLOTS; i++) begin
        s = int'((home + i * stride) % dhot_pkg::TABLE_SLOTS);
        if (!slot_used[s]) return r;
        if (slot_key[s] == k) begin
          r.success     = 1'b1;
          r.payload_out = slot_payload[s];
          return r;
        end
      end
      return r;
    endfunction

    function void note_word(dhot_pkg::in_item_t w);
      due_results.push_back(run_op(w));
    endfunction

    function void check_word(dhot_pkg::out_item_t got);
      dhot_pkg::out_item_t want;
      if (due_results.size() == 0) begin
        $error("result word with none expected: success %0d payload_out %h",
               got.success, got.payload_out);
        fail_count++;
        return;
      end
      want = due_results.pop_front();
      if (got.success !== want.success) begin
        $error("success: expected %0d, actual %0d", want.success, got.success);
        fail_count++;
      end
      if (got.payload_out !== want.payload_out) begin
        $error("payload_out: expected %h, actual %h", want.payload_out, got.payload_out);
        fail_count++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  dhot_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  dhot_pkg::out_item_t out_data;

  slot_table_scoreboard       sb;
  logic [dhot_pkg::KEY_W-1:0] known_keys [$];
  int                         burst_left = 4;

  double_hash_open_address_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [dhot_pkg::KEY_W-1:0] random_key();
    if ($urandom_range(0, 3) == 0) return dhot_pkg::KEY_W'($urandom_range(0, 4095));
    return dhot_pkg::KEY_W'($urandom());
  endfunction

  function automatic logic [dhot_pkg::KEY_W-1:0] pick_known_key();
    return known_keys[$urandom_range(0, known_keys.size() - 1)];
  endfunction

  // hold the word until accepted, then end the burst with a gap if due
  task automatic push_op(input dhot_pkg::mode_e m,
                         input logic [dhot_pkg::KEY_W-1:0] k,
                         input logic [dhot_pkg::PAYLOAD_W-1:0] p);
    dhot_pkg::in_item_t w;
    w.mode       = m;
    w.key        = k;
    w.payload_in = p;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk_i); while (!in_ready);
    sb.note_word(w);
    if (m == dhot_pkg::MODE_INSERT) known_keys.push_back(k);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
    end
  endtask

  // receiver: the stall pattern is redrawn at random among always, mostly and seldom ready
  initial begin
    int stall_mode;
    int mode_left;
    stall_mode = 0;
    mode_left  = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid && out_ready) sb.check_word(out_data);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(32, 256);
      end
      mode_left--;
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    #100_000_000;
    $display("double_hash_open_address_table_test: done, errors");
    $finish;
  end

  initial begin
    int filled;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // empty table: lookups stop at the first empty slot
    push_op(dhot_pkg::MODE_LOOKUP, '0, '0);
    push_op(dhot_pkg::MODE_LOOKUP, '1, '1);
    push_op(dhot_pkg::MODE_INSERT, '0, '0);
    push_op(dhot_pkg::MODE_INSERT, '1, '1);
    push_op(dhot_pkg::MODE_LOOKUP, '0, '1);
    push_op(dhot_pkg::MODE_LOOKUP, '1, '0);
    // duplicate key: lookup must return the first record
    push_op(dhot_pkg::MODE_INSERT, '1, 64'h0123_4567_89ab_cdef);
    push_op(dhot_pkg::MODE_LOOKUP, '1, 64'h5555_5555_5555_5555);
    // step folds to zero: every probe lands on the home slot
    push_op(dhot_pkg::MODE_INSERT, 31'h000f_fc00, 64'haaaa_aaaa_aaaa_aaaa);
    push_op(dhot_pkg::MODE_INSERT, 31'h000f_fc00, 64'h5555_5555_5555_5555);
    push_op(dhot_pkg::MODE_LOOKUP, 31'h000f_fc00, '0);
    // home slot beyond the table, path held by another key
    push_op(dhot_pkg::MODE_LOOKUP, 31'h001f_fc00, '0);
    push_op(dhot_pkg::MODE_INSERT, 31'h001f_fc00, 64'h8000_0000_0000_0001);
    push_op(dhot_pkg::MODE_LOOKUP, 31'h001f_fc00, '0);
    push_op(dhot_pkg::MODE_LOOKUP, 31'h4000_0000, '1);

    // random mix, table fills to moderate load
    repeat (900) begin
      if ($urandom_range(0, 99) < 60) begin
        push_op(dhot_pkg::MODE_INSERT,
                ($urandom_range(0, 9) < 2) ? pick_known_key() : random_key(),
                {$urandom(), $urandom()});
      end else begin
        push_op(dhot_pkg::MODE_LOOKUP,
                ($urandom_range(0, 9) < 6) ? pick_known_key() : random_key(),
                {$urandom(), $urandom()});
      end
    end

    // fill every slot, then work on the full table
    filled = 0;
    while (sb.entries < dhot_pkg::TABLE_SLOTS && filled < 1000) begin
      push_op(dhot_pkg::MODE_INSERT, random_key(), {$urandom(), $urandom()});
      filled++;
    end
    repeat (24) begin
      case ($urandom_range(0, 2))
        0: push_op(dhot_pkg::MODE_INSERT, random_key(), {$urandom(), $urandom()});
        1: push_op(dhot_pkg::MODE_LOOKUP, pick_known_key(), {$urandom(), $urandom()});
        default: push_op(dhot_pkg::MODE_LOOKUP, random_key(), {$urandom(), $urandom()});
      endcase
    end
    in_valid <= 1'b0;

    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (sb.fail_count == 0) begin
      $display("double_hash_open_address_table_test: done, clean");
    end else begin
      $display("double_hash_open_address_table_test: done, errors");
    end
    $finish;
  end

endmodule
